// ===== src/dsu_pkg.sv =====
// ----------------------------------------------------------------------------
// dsu_pkg
// Shared widths, command codes and controller/datapath handshake types for
// the disjoint-set table.
// ----------------------------------------------------------------------------
`default_nettype none

package dsu_pkg;

  localparam int ELEM_W       = 10;
  localparam int CMD_W        = 2;
  localparam int RANK_W       = 4;
  localparam int DSU_ELEMENTS = 1024;

  localparam logic [RANK_W-1:0] RANK_MAX = '1;

  // Command codes carried on the input word
  localparam logic [CMD_W-1:0] CMD_FIND  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UNITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  typedef logic [ELEM_W-1:0] elem_t;
  typedef logic [CMD_W-1:0]  cmd_code_t;
  typedef logic [RANK_W-1:0] rank_t;

  // Datapath micro-operations, one per controller cycle
  typedef enum logic [3:0] {
    DP_NOP,
    DP_CAP,     // capture input word
    DP_CLR,     // one step of the table sweep
    DP_FSTART,  // start a find on elem_a or elem_b
    DP_WRD,     // walk: read parent of cursor
    DP_WCHK,    // walk: follow pointer or stop at root
    DP_CRD,     // compress: read parent of cursor
    DP_CCHK,    // compress: point cursor at root, advance
    DP_FEND,    // latch root of this find
    DP_RKA,     // read rank of first root
    DP_RKB,     // read rank of second root
    DP_LINK     // hang one root under the other
  } dp_op_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_FOUND,
    RES_RA,
    RES_LINK
  } res_src_t;

  typedef struct packed {
    dp_op_t   op;
    logic     sel_b;
    logic     res_wr;
    res_src_t res_src;
    logic     out_load;
    logic     in_ready;
  } dsu_cmd_t;

  typedef struct packed {
    logic e_in;      // selected element lies inside the table
    logic hit;       // parent read back equals cursor: root reached
    logic e_is_cur;  // start element is the root itself
    logic comp_end;  // parent read back is the root: path done
    logic link_ok;   // both in table and roots differ
    logic clr_last;  // sweep at last entry
    logic out_free;  // output register can take a word
  } dsu_sts_t;

endpackage

`default_nettype wire

// ===== src/dsu_ifs.sv =====
// ----------------------------------------------------------------------------
// dsu channel interfaces
// Valid/ready channels for the command word and the result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface dsu_in_if import dsu_pkg::*; ();
  logic      valid;
  logic      ready;
  cmd_code_t cmd;
  elem_t     elem_a;
  elem_t     elem_b;

  modport source (output valid, output cmd, output elem_a, output elem_b, input ready);
  modport sink   (input valid, input cmd, input elem_a, input elem_b, output ready);
endinterface

interface dsu_out_if import dsu_pkg::*; ();
  logic  valid;
  logic  ready;
  elem_t root;
  logic  merged;

  modport source (output valid, output root, output merged, input ready);
  modport sink   (input valid, input root, input merged, output ready);
endinterface

`default_nettype wire

// ===== src/dsu_ctrl.sv =====
// ----------------------------------------------------------------------------
// dsu_ctrl
// Sequencer for sweep, two-pass find, rank compare and link.
// ----------------------------------------------------------------------------
`default_nettype none

module dsu_ctrl import dsu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  cmd_code_t in_cmd,
  input  dsu_sts_t  sts,
  output dsu_cmd_t  ctl
);

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_FSTART,
    S_WRD,
    S_WCHK,
    S_CRD,
    S_CCHK,
    S_FEND,
    S_RKA,
    S_RKB,
    S_LINK,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   phase_r, phase_nxt;      // 0: finding elem_a, 1: elem_b
  logic   unite_r, unite_nxt;
  logic   clr_rpt_r, clr_rpt_nxt;  // sweep was commanded, report a word

  always_comb begin
    ctl         = '0;
    ctl.op      = DP_NOP;
    ctl.res_src = RES_ZERO;
    ctl.sel_b   = phase_r;
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    unite_nxt   = unite_r;
    clr_rpt_nxt = clr_rpt_r;
    unique case (state_r)
      S_CLR: begin
        ctl.op = DP_CLR;
        if (sts.clr_last) begin
          state_nxt = clr_rpt_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        ctl.in_ready = 1'b1;
        if (in_valid) begin
          ctl.op    = DP_CAP;
          phase_nxt = 1'b0;
          unique case (in_cmd)
            CMD_FIND: begin
              unite_nxt = 1'b0;
              state_nxt = S_FSTART;
            end
            CMD_UNITE: begin
              unite_nxt = 1'b1;
              state_nxt = S_FSTART;
            end
            CMD_CLEAR: begin
              ctl.res_wr  = 1'b1;
              clr_rpt_nxt = 1'b1;
              state_nxt   = S_CLR;
            end
            default: begin
              ctl.res_wr = 1'b1;
              state_nxt  = S_DONE;
            end
          endcase
        end
      end
      S_FSTART: begin
        ctl.op    = DP_FSTART;
        state_nxt = sts.e_in ? S_WRD : S_FEND;
      end
      S_WRD: begin
        ctl.op    = DP_WRD;
        state_nxt = S_WCHK;
      end
      S_WCHK: begin
        ctl.op = DP_WCHK;
        if (sts.hit) begin
          state_nxt = sts.e_is_cur ? S_FEND : S_CRD;
        end else begin
          state_nxt = S_WRD;
        end
      end
      S_CRD: begin
        ctl.op    = DP_CRD;
        state_nxt = S_CCHK;
      end
      S_CCHK: begin
        ctl.op    = DP_CCHK;
        state_nxt = sts.comp_end ? S_FEND : S_CRD;
      end
      S_FEND: begin
        ctl.op = DP_FEND;
        if (!unite_r) begin
          ctl.res_wr  = 1'b1;
          ctl.res_src = RES_FOUND;
          state_nxt   = S_DONE;
        end else if (!phase_r) begin
          phase_nxt = 1'b1;
          state_nxt = S_FSTART;
        end else if (sts.link_ok) begin
          state_nxt = S_RKA;
        end else begin
          ctl.res_wr  = 1'b1;
          ctl.res_src = RES_RA;
          state_nxt   = S_DONE;
        end
      end
      S_RKA: begin
        ctl.op    = DP_RKA;
        state_nxt = S_RKB;
      end
      S_RKB: begin
        ctl.op    = DP_RKB;
        state_nxt = S_LINK;
      end
      S_LINK: begin
        ctl.op      = DP_LINK;
        ctl.res_wr  = 1'b1;
        ctl.res_src = RES_LINK;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          clr_rpt_nxt  = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      phase_r   <= 1'b0;
      unite_r   <= 1'b0;
      clr_rpt_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      unite_r   <= unite_nxt;
      clr_rpt_r <= clr_rpt_nxt;
    end
  end

  a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> sts.out_free)
    else $error("result loaded into occupied output register");

  a_clr_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && ctl.in_ready && in_cmd == CMD_CLEAR) |=> (state_r == S_CLR && clr_rpt_r))
    else $error("clear command did not start a reported sweep");

  a_link_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LINK) |-> (unite_r && phase_r && $past(state_r) == S_RKB))
    else $error("link outside a unite after both finds");

endmodule

`default_nettype wire

// ===== src/dsu_datapath.sv =====
// ----------------------------------------------------------------------------
// dsu_datapath
// Parent and rank memories, find cursor, result and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module dsu_datapath import dsu_pkg::*; #(
  parameter int ELEMENTS = DSU_ELEMENTS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  dsu_cmd_t ctl,
  output dsu_sts_t sts,
  input  elem_t    in_elem_a,
  input  elem_t    in_elem_b,
  input  logic     out_ready,
  output logic     out_valid,
  output elem_t    out_root,
  output logic     out_merged
);

  localparam int IDX_W = $clog2(ELEMENTS);
  typedef logic [IDX_W-1:0] idx_t;

  idx_t  parent_mem [ELEMENTS];
  rank_t rank_mem   [ELEMENTS];

  idx_t  parent_rd_r;
  rank_t rank_rd_r;

  elem_t a_r, b_r, fres_r, ra_r;
  idx_t  e_r, cur_r, froot_r, cnt_r;
  rank_t rank_a_r;
  elem_t res_root_r, out_root_r;
  logic  res_merged_r, out_merged_r, out_valid_r;

  elem_t sel_elem;
  logic  a_in, b_in;
  idx_t  ra_idx, rb_idx, keep_idx, drop_idx;
  logic  b_wins, rank_bump;

  // memory port controls
  logic  pw_en, pr_en, rw_en, rr_en;
  idx_t  pw_addr, pw_data, pr_addr, rw_addr, rr_addr;
  rank_t rw_data;

  assign sel_elem = ctl.sel_b ? b_r : a_r;
  assign a_in     = 32'(a_r) < ELEMENTS;
  assign b_in     = 32'(b_r) < ELEMENTS;
  assign ra_idx   = idx_t'(ra_r);
  assign rb_idx   = idx_t'(fres_r);   // second root stays in fres_r
  assign b_wins   = rank_a_r < rank_rd_r;
  assign keep_idx = b_wins ? rb_idx : ra_idx;
  assign drop_idx = b_wins ? ra_idx : rb_idx;
  assign rank_bump = (rank_a_r == rank_rd_r) && (rank_a_r != RANK_MAX);

  assign sts.e_in     = 32'(sel_elem) < ELEMENTS;
  assign sts.hit      = parent_rd_r == cur_r;
  assign sts.e_is_cur = e_r == cur_r;
  assign sts.comp_end = parent_rd_r == froot_r;
  assign sts.link_ok  = a_in && b_in && (ra_r != fres_r);
  assign sts.clr_last = cnt_r == idx_t'(ELEMENTS - 1);
  assign sts.out_free = !out_valid_r || out_ready;

  always_comb begin
    pw_en   = 1'b0;
    pw_addr = cur_r;
    pw_data = froot_r;
    pr_en   = 1'b0;
    pr_addr = cur_r;
    rw_en   = 1'b0;
    rw_addr = keep_idx;
    rw_data = rank_a_r + rank_t'(1);
    rr_en   = 1'b0;
    rr_addr = ra_idx;
    unique case (ctl.op)
      DP_CLR: begin
        pw_en   = 1'b1;
        pw_addr = cnt_r;
        pw_data = cnt_r;
        rw_en   = 1'b1;
        rw_addr = cnt_r;
        rw_data = '0;
      end
      DP_WRD, DP_CRD: begin
        pr_en = 1'b1;
      end
      DP_CCHK: begin
        pw_en = 1'b1;
      end
      DP_RKA: begin
        rr_en = 1'b1;
      end
      DP_RKB: begin
        rr_en   = 1'b1;
        rr_addr = rb_idx;
      end
      DP_LINK: begin
        pw_en   = 1'b1;
        pw_addr = drop_idx;
        pw_data = keep_idx;
        rw_en   = rank_bump;
      end
      default: begin
      end
    endcase
  end

  // tables: one write and one registered read per cycle each
  always_ff @(posedge clk) begin
    if (pw_en) begin
      parent_mem[pw_addr] <= pw_data;
    end
    if (pr_en) begin
      parent_rd_r <= parent_mem[pr_addr];
    end
    if (rw_en) begin
      rank_mem[rw_addr] <= rw_data;
    end
    if (rr_en) begin
      rank_rd_r <= rank_mem[rr_addr];
    end
  end

  // payload
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      DP_CAP: begin
        a_r <= in_elem_a;
        b_r <= in_elem_b;
      end
      DP_FSTART: begin
        e_r    <= idx_t'(sel_elem);
        cur_r  <= idx_t'(sel_elem);
        fres_r <= sel_elem;   // kept as-is when outside the table
      end
      DP_WCHK: begin
        if (sts.hit) begin
          froot_r <= cur_r;
          fres_r  <= elem_t'(cur_r);
          cur_r   <= e_r;
        end else begin
          cur_r <= parent_rd_r;
        end
      end
      DP_CCHK: begin
        cur_r <= parent_rd_r;
      end
      DP_FEND: begin
        if (!ctl.sel_b) begin
          ra_r <= fres_r;
        end
      end
      DP_RKB: begin
        rank_a_r <= rank_rd_r;
      end
      default: begin
      end
    endcase
    if (ctl.res_wr) begin
      unique case (ctl.res_src)
        RES_ZERO: begin
          res_root_r   <= '0;
          res_merged_r <= 1'b0;
        end
        RES_FOUND: begin
          res_root_r   <= fres_r;
          res_merged_r <= 1'b0;
        end
        RES_RA: begin
          res_root_r   <= ra_r;
          res_merged_r <= 1'b0;
        end
        RES_LINK: begin
          res_root_r   <= elem_t'(keep_idx);
          res_merged_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
    if (ctl.out_load) begin
      out_root_r   <= res_root_r;
      out_merged_r <= res_merged_r;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.op == DP_CLR) begin
        cnt_r <= sts.clr_last ? '0 : cnt_r + idx_t'(1);
      end
      if (ctl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_root   = out_root_r;
  assign out_merged = out_merged_r;

  a_comp_not_root: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == DP_CCHK) |-> (cur_r != froot_r))
    else $error("path compression rewrote the root entry");

  a_link_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == DP_LINK) |-> (keep_idx != drop_idx))
    else $error("link of a root under itself");

endmodule

`default_nettype wire

// ===== src/disjoint_set_union_find.sv =====
// Find: walk from the element to its root, then rewrite the path to point at the root.
// Unite: both finds, then rank reads and link; path length to root d <= log2(ELEMENTS).
// Each walk or compression step is a read state then a check state on the single parent-table read port.
// Clear: sweep of the table, one table entry rewritten per cycle, then a result word.
// Reset: sweep of all ELEMENTS entries restores identity parents and zero ranks, ready low.
// Next word is taken once the result is in the output register, even if not yet read.
// ----------------------------------------------------------------------------
// disjoint_set_union_find
// Union-find table with union by rank and full path compression. A
// controller steps a datapath holding the parent and rank memories.
// ----------------------------------------------------------------------------
`default_nettype none

module disjoint_set_union_find import dsu_pkg::*; #(
  parameter int ELEMENTS = DSU_ELEMENTS
) (
  input  logic         clk,
  input  logic         rst_n,
  dsu_in_if.sink       in_ch,
  dsu_out_if.source    out_ch
);

  // controller -> datapath commands, datapath -> controller status
  dsu_cmd_t ctl;
  dsu_sts_t sts;

  // Sequencer: sweep after reset/clear, find = walk to root then
  // rewrite path, unite = find(a), find(b), rank compare, link.
  dsu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .sts      (sts),
    .ctl      (ctl)
  );

  // word accepted only while the sequencer idles
  assign in_ch.ready = ctl.in_ready;

  // Tables, cursor registers and the output register that decouples
  // result delivery from the next command.
  dsu_datapath #(
    .ELEMENTS (ELEMENTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .sts        (sts),
    .in_elem_a  (in_ch.elem_a),
    .in_elem_b  (in_ch.elem_b),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_root   (out_ch.root),
    .out_merged (out_ch.merged)
  );

endmodule

`default_nettype wire
